### rtl/ame_pkg.sv
// shared types, opcodes and constants for the accumulator machine execute core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ame_pkg;

    localparam int DataDepthDefault    = 256;
    localparam int ProgramDepthDefault = 1024;

    localparam int PcW   = 11;
    localparam int LenW  = 9;
    localparam int WordW = 64;
    localparam int ArgW  = 32;
    localparam int OpW   = 5;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_HALTED  = 2'd1,
        ST_ERRORED = 2'd2
    } run_status_t;

    localparam logic [OpW-1:0] OP_CLEAR  = 5'd0;
    localparam logic [OpW-1:0] OP_AT     = 5'd1;
    localparam logic [OpW-1:0] OP_SET    = 5'd2;
    localparam logic [OpW-1:0] OP_INSERT = 5'd3;
    localparam logic [OpW-1:0] OP_ERASE  = 5'd4;
    localparam logic [OpW-1:0] OP_CADD   = 5'd5;
    localparam logic [OpW-1:0] OP_CSUB   = 5'd6;
    localparam logic [OpW-1:0] OP_CMUL   = 5'd7;
    localparam logic [OpW-1:0] OP_CDIV   = 5'd8;
    localparam logic [OpW-1:0] OP_MADD   = 5'd9;
    localparam logic [OpW-1:0] OP_MSUB   = 5'd10;
    localparam logic [OpW-1:0] OP_MMUL   = 5'd11;
    localparam logic [OpW-1:0] OP_MDIV   = 5'd12;
    localparam logic [OpW-1:0] OP_JREL   = 5'd13;
    localparam logic [OpW-1:0] OP_JZERO  = 5'd14;
    localparam logic [OpW-1:0] OP_JNZERO = 5'd15;
    localparam logic [OpW-1:0] OP_NOOP   = 5'd16;
    localparam logic [OpW-1:0] OP_HALT   = 5'd17;
    localparam logic [OpW-1:0] OP_OUTPUT = 5'd18;
    localparam logic [OpW-1:0] OP_CHKMEM = 5'd19;

    // arithmetic function codes for the datapath
    typedef enum logic [2:0] {
        ALU_CLEAR = 3'd0,
        ALU_ADD   = 3'd1,
        ALU_SUB   = 3'd2,
        ALU_LOAD  = 3'd3
    } alu_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic        acc_wr;       // write acc from alu
        alu_op_t     alu_op;
        logic        opnd_mem;     // operand from memory read register
        logic        mul_step;     // one multiplier partial product step
        logic        mul_init;
        logic        div_init;
        logic        div_step;
        logic        div_done;     // write quotient into acc
        logic        mem_rd;       // read memory at rd_addr
        logic        mem_wr;       // write memory at wr_addr
        logic        wr_src_acc;   // write data acc, else read register
    } ame_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic acc_zero;
        logic opnd_zero;
    } ame_stat_t;

endpackage
`default_nettype wire

### rtl/accumulator_machine_execute_top.sv
// top level of the accumulator machine execute core
// depends on ame_pkg, ame_ctrl and ame_datapath
`timescale 1ns / 1ps
`default_nettype none
// usage
// - input channel: drive kind, opcode, argument, load_word with start; the
//   transfer happens at a rising edge with start high and busy low
// - result channel: done is high for one cycle with status, next_pc,
//   accumulator_value, print_valid and memory_length; the receiver has no
//   way to stall it, so results must be taken in that cycle
// - program_length is written with cfg_we and cfg_wdata while idle
// sequence from start transfer to done
// - load and non-running execute: straight to the result strobe
// - simple ops and jumps: read, execute, pc advance (memory read is always issued)
// - multiply: one bit per cycle in the shift-add unit
// - divide: one bit per cycle in the restoring divider
// - insert and erase: each shifted word is read, then written back
// one item at a time; busy stays high through the done cycle
// reset clears acc, pc, length and sets status to halted; the data memory
// is not cleared and only entries below the length are ever used
module accumulator_machine_execute_top #(
    parameter int DATA_DEPTH    = ame_pkg::DataDepthDefault,
    parameter int PROGRAM_DEPTH = ame_pkg::ProgramDepthDefault
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         kind,
    input  wire logic [ame_pkg::OpW-1:0]      opcode,
    input  wire logic [ame_pkg::ArgW-1:0]     argument,
    input  wire logic [ame_pkg::WordW-1:0]    load_word,
    input  wire logic                         cfg_we,
    input  wire logic [ame_pkg::PcW-1:0]      cfg_wdata,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [ame_pkg::PcW-1:0]           next_pc,
    output logic [ame_pkg::WordW-1:0]         accumulator_value,
    output logic                              print_valid,
    output logic [ame_pkg::LenW-1:0]          memory_length
);
    localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

    ame_pkg::ame_cmd_t  cmd;
    ame_pkg::ame_stat_t stat;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [ame_pkg::ArgW-1:0] arg_q;
    logic               load_wr;

    // sequencing, pc, status and memory length
    ame_ctrl #(
        .DATA_DEPTH    (DATA_DEPTH),
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .AW            (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .kind          (kind),
        .opcode        (opcode),
        .argument      (argument),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .stat          (stat),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .arg_q         (arg_q),
        .load_wr       (load_wr),
        .busy          (busy),
        .done          (done),
        .status        (status),
        .next_pc       (next_pc),
        .print_valid   (print_valid),
        .memory_length (memory_length)
    );

    // accumulator, data memory and the iterative arithmetic units
    ame_datapath #(
        .DATA_DEPTH (DATA_DEPTH),
        .AW         (AW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .arg       (arg_q),
        .load_wr   (load_wr),
        .load_data (load_word),
        .stat      (stat),
        .acc       (accumulator_value)
    );

    // a result strobe always follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("done without work");
    // print only together with the result strobe
    assert property (@(posedge clk) disable iff (!rst_n) print_valid |-> done)
        else $error("print outside result");
    // memory length never exceeds the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        memory_length <= ame_pkg::LenW'(DATA_DEPTH))
        else $error("memory length overflow");
endmodule
`default_nettype wire

### rtl/ame_datapath.sv
// datapath: accumulator, data memory, shift-add multiplier, restoring divider
// depends on ame_pkg
`timescale 1ns / 1ps
`default_nettype none
module ame_datapath #(
    parameter int DATA_DEPTH = ame_pkg::DataDepthDefault,
    parameter int AW         = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ame_pkg::ame_cmd_t           cmd,
    input  wire logic [AW-1:0]               rd_addr,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [ame_pkg::ArgW-1:0]    arg,
    input  wire logic                        load_wr,
    input  wire logic [ame_pkg::WordW-1:0]   load_data,
    output ame_pkg::ame_stat_t               stat,
    output logic [ame_pkg::WordW-1:0]        acc
);
    localparam int W = ame_pkg::WordW;

    logic [W-1:0] mem [DATA_DEPTH];
    logic [W-1:0] rd_reg;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] opnd;

    // multiply / divide working registers
    logic [W-1:0] ma_reg, ma_next;     // multiplicand or divisor
    logic [W-1:0] mb_reg, mb_next;     // multiplier or dividend/quotient
    logic [W-1:0] prod_reg, prod_next;
    logic         neg_reg, neg_next;

    logic [W-1:0] argx;
    logic [W-1:0] abs_a, abs_b;
    logic [W:0]   trial;
    logic [W-1:0] rem_sh;

    assign argx = {{(W-ame_pkg::ArgW){arg[ame_pkg::ArgW-1]}}, arg};
    assign opnd = cmd.opnd_mem ? rd_reg : argx;
    assign abs_a = acc_reg[W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign abs_b = opnd[W-1] ? (~opnd + 1'b1) : opnd;
    assign rem_sh = {prod_reg[W-2:0], mb_reg[W-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, ma_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            rd_reg <= mem[rd_addr];
        end
        if (load_wr)
        begin
            mem[wr_addr] <= load_data;
        end
        else if (cmd.mem_wr)
        begin
            mem[wr_addr] <= cmd.wr_src_acc ? acc_reg : rd_reg;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        prod_next = prod_reg;
        neg_next  = neg_reg;
        if (cmd.acc_wr)
        begin
            case (cmd.alu_op)
                ame_pkg::ALU_CLEAR: acc_next = '0;
                ame_pkg::ALU_ADD:   acc_next = acc_reg + opnd;
                ame_pkg::ALU_SUB:   acc_next = acc_reg - opnd;
                ame_pkg::ALU_LOAD:  acc_next = opnd;
                default:            acc_next = acc_reg;
            endcase
        end
        if (cmd.mul_init)
        begin
            ma_next   = acc_reg;
            mb_next   = opnd;
            prod_next = '0;
        end
        else if (cmd.mul_step)
        begin
            // one bit per cycle, low bits first
            if (mb_reg[0])
            begin
                prod_next = prod_reg + ma_reg;
            end
            ma_next = {ma_reg[W-2:0], 1'b0};
            mb_next = {1'b0, mb_reg[W-1:1]};
            acc_next = (mb_reg[W-1:1] == '0) ? prod_next : acc_reg;
        end
        if (cmd.div_init)
        begin
            ma_next   = abs_b;
            mb_next   = abs_a;
            prod_next = '0;
            neg_next  = acc_reg[W-1] ^ opnd[W-1];
        end
        else if (cmd.div_step)
        begin
            // restoring division, quotient bits shift into mb
            if (!trial[W])
            begin
                prod_next = trial[W-1:0];
                mb_next   = {mb_reg[W-2:0], 1'b1};
            end
            else
            begin
                prod_next = rem_sh;
                mb_next   = {mb_reg[W-2:0], 1'b0};
            end
        end
        if (cmd.div_done)
        begin
            acc_next = neg_reg ? (~mb_reg + 1'b1) : mb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
    end

    assign acc = acc_reg;
    assign stat.acc_zero  = (acc_reg == '0);
    assign stat.opnd_zero = (opnd == '0);
endmodule
`default_nettype wire

### rtl/ame_ctrl.sv
// controller state machine: sequencing, pc, length, status and result strobe
// depends on ame_pkg
`timescale 1ns / 1ps
`default_nettype none
module ame_ctrl #(
    parameter int DATA_DEPTH    = ame_pkg::DataDepthDefault,
    parameter int PROGRAM_DEPTH = ame_pkg::ProgramDepthDefault,
    parameter int AW            = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       kind,
    input  wire logic [ame_pkg::OpW-1:0]    opcode,
    input  wire logic [ame_pkg::ArgW-1:0]   argument,
    input  wire logic                       cfg_we,
    input  wire logic [ame_pkg::PcW-1:0]    cfg_wdata,
    input  wire ame_pkg::ame_stat_t         stat,
    output ame_pkg::ame_cmd_t               cmd,
    output logic [AW-1:0]                   rd_addr,
    output logic [AW-1:0]                   wr_addr,
    output logic [ame_pkg::ArgW-1:0]        arg_q,
    output logic                            load_wr,
    output logic                            busy,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [ame_pkg::PcW-1:0]         next_pc,
    output logic                            print_valid,
    output logic [ame_pkg::LenW-1:0]        memory_length
);
    localparam int W   = ame_pkg::WordW;
    localparam int LW  = ame_pkg::LenW;
    localparam int PW  = ame_pkg::PcW;
    localparam int CW  = $clog2(W + 1);
    localparam int SW  = ame_pkg::ArgW + 2;   // signed pc sum width
    localparam logic [LW-1:0] DEPTH_L = LW'(DATA_DEPTH);
    localparam logic [PW-1:0] PDEPTH  = PW'(PROGRAM_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDW, S_EXEC, S_MUL, S_DIVI, S_DIV, S_DIVD,
        S_SHRD, S_SHWR, S_ADV, S_DONE
    } state_t;

    state_t                 state_reg;
    logic [ame_pkg::OpW-1:0] op_reg;
    logic [ame_pkg::ArgW-1:0] arg_reg;
    logic [LW-1:0]          len_reg;
    logic [PW-1:0]          pc_reg;
    logic [PW-1:0]          plen_reg;
    ame_pkg::run_status_t   st_reg;
    logic                   print_reg;
    logic                   done_reg;
    logic                   jump_reg;
    logic [CW-1:0]          cnt_reg;
    logic [LW-1:0]          sh_reg;       // shift cursor

    logic arg_neg, idx_ok, ins_ok, chk_ok;
    logic accept_item;
    logic [PW-1:0] cfg_len;
    logic signed [SW-1:0] np;
    logic [AW-1:0] idx;

    // no transfer during the result cycle, busy is still high there
    assign accept_item = start && !done_reg;
    assign arg_neg = arg_reg[ame_pkg::ArgW-1];
    assign idx_ok  = !arg_neg && ({1'b0, arg_reg} < {{(ame_pkg::ArgW+1-LW){1'b0}}, len_reg});
    assign ins_ok  = !arg_neg && ({1'b0, arg_reg} <= {{(ame_pkg::ArgW+1-LW){1'b0}}, len_reg})
                     && (len_reg < DEPTH_L);
    assign chk_ok  = !arg_neg && ({1'b0, arg_reg} <=
                     {{(ame_pkg::ArgW+1-LW){1'b0}}, len_reg});
    assign idx     = arg_reg[AW-1:0];
    assign cfg_len = (cfg_wdata > PDEPTH) ? PDEPTH : cfg_wdata;
    assign np = $signed({{(SW-PW){1'b0}}, pc_reg}) +
                (jump_reg ? $signed({{(SW-ame_pkg::ArgW){arg_neg}}, arg_reg})
                          : $signed(SW'(1)));

    always_comb
    begin
        cmd = '0;
        rd_addr = idx;
        wr_addr = len_reg[AW-1:0];
        load_wr = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                load_wr = accept_item && !kind && (len_reg < DEPTH_L);
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
            end
            S_EXEC:
            begin
                cmd.opnd_mem = (op_reg >= ame_pkg::OP_MADD);
                case (op_reg)
                    ame_pkg::OP_CLEAR:
                    begin
                        cmd.acc_wr = 1'b1;
                        cmd.alu_op = ame_pkg::ALU_CLEAR;
                    end
                    ame_pkg::OP_AT:
                    begin
                        cmd.acc_wr = idx_ok;
                        cmd.alu_op = ame_pkg::ALU_LOAD;
                        cmd.opnd_mem = 1'b1;
                    end
                    ame_pkg::OP_SET:
                    begin
                        cmd.mem_wr = idx_ok;
                        cmd.wr_src_acc = 1'b1;
                        wr_addr = idx;
                    end
                    ame_pkg::OP_CADD, ame_pkg::OP_MADD:
                    begin
                        // a bad memory index leaves acc alone
                        cmd.acc_wr = (op_reg == ame_pkg::OP_CADD) || idx_ok;
                        cmd.alu_op = ame_pkg::ALU_ADD;
                    end
                    ame_pkg::OP_CSUB, ame_pkg::OP_MSUB:
                    begin
                        cmd.acc_wr = (op_reg == ame_pkg::OP_CSUB) || idx_ok;
                        cmd.alu_op = ame_pkg::ALU_SUB;
                    end
                    ame_pkg::OP_CMUL, ame_pkg::OP_MMUL:
                    begin
                        cmd.mul_init = 1'b1;
                    end
                    ame_pkg::OP_CDIV, ame_pkg::OP_MDIV:
                    begin
                        cmd.div_init = !stat.opnd_zero;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_DIVD:
            begin
                cmd.div_done = 1'b1;
            end
            S_SHRD:
            begin
                // insert reads below cursor, erase reads above
                cmd.mem_rd = 1'b1;
                rd_addr = (op_reg == ame_pkg::OP_INSERT) ? AW'(sh_reg - 1'b1)
                                                         : AW'(sh_reg + 1'b1);
            end
            S_SHWR:
            begin
                cmd.mem_wr = 1'b1;
                wr_addr = sh_reg[AW-1:0];
            end
            S_ADV:
            begin
                if (op_reg == ame_pkg::OP_INSERT)
                begin
                    cmd.mem_wr = 1'b1;
                    cmd.wr_src_acc = 1'b1;
                    wr_addr = idx;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            arg_reg   <= '0;
            len_reg   <= '0;
            pc_reg    <= '0;
            plen_reg  <= '0;
            st_reg    <= ame_pkg::ST_HALTED;
            print_reg <= 1'b0;
            done_reg  <= 1'b0;
            jump_reg  <= 1'b0;
            cnt_reg   <= '0;
            sh_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                plen_reg <= cfg_len;
                if (st_reg != ame_pkg::ST_ERRORED)
                begin
                    st_reg <= (pc_reg < cfg_len) ? ame_pkg::ST_RUNNING
                                                 : ame_pkg::ST_HALTED;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept_item)
                    begin
                        op_reg    <= opcode;
                        arg_reg   <= argument;
                        print_reg <= 1'b0;
                        jump_reg  <= 1'b0;
                        if (!kind)
                        begin
                            if (len_reg < DEPTH_L)
                            begin
                                len_reg <= len_reg + 1'b1;
                            end
                            else
                            begin
                                st_reg <= ame_pkg::ST_ERRORED;
                            end
                            state_reg <= S_DONE;
                        end
                        else if (st_reg != ame_pkg::ST_RUNNING)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_RDW;
                end
                S_RDW:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_ADV;
                    cnt_reg   <= '0;
                    case (op_reg)
                        ame_pkg::OP_CLEAR, ame_pkg::OP_CADD, ame_pkg::OP_CSUB,
                        ame_pkg::OP_NOOP:
                        begin
                        end
                        ame_pkg::OP_AT, ame_pkg::OP_SET, ame_pkg::OP_MADD,
                        ame_pkg::OP_MSUB:
                        begin
                            if (!idx_ok)
                            begin
                                st_reg <= ame_pkg::ST_ERRORED;
                                state_reg <= S_DONE;
                            end
                        end
                        ame_pkg::OP_CMUL:
                        begin
                            state_reg <= S_MUL;
                        end
                        ame_pkg::OP_MMUL:
                        begin
                            if (!idx_ok)
                            begin
                                st_reg <= ame_pkg::ST_ERRORED;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_MUL;
                            end
                        end
                        ame_pkg::OP_CDIV, ame_pkg::OP_MDIV:
                        begin
                            if ((op_reg == ame_pkg::OP_MDIV && !idx_ok) ||
                                stat.opnd_zero)
                            begin
                                st_reg <= ame_pkg::ST_ERRORED;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_DIV;
                            end
                        end
                        ame_pkg::OP_INSERT:
                        begin
                            if (!ins_ok)
                            begin
                                st_reg <= ame_pkg::ST_ERRORED;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                sh_reg <= len_reg;
                                state_reg <= (len_reg == LW'(arg_reg)) ? S_ADV : S_SHRD;
                            end
                        end
                        ame_pkg::OP_ERASE:
                        begin
                            if (!idx_ok)
                            begin
                                st_reg <= ame_pkg::ST_ERRORED;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                sh_reg <= LW'(arg_reg);
                                state_reg <= (LW'(arg_reg) + 1'b1 == len_reg) ? S_ADV
                                                                              : S_SHRD;
                            end
                        end
                        ame_pkg::OP_JREL, ame_pkg::OP_JZERO, ame_pkg::OP_JNZERO:
                        begin
                            if (arg_reg == '0)
                            begin
                                st_reg <= ame_pkg::ST_ERRORED;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                jump_reg <= (op_reg == ame_pkg::OP_JREL) ||
                                            (op_reg == ame_pkg::OP_JZERO && stat.acc_zero) ||
                                            (op_reg == ame_pkg::OP_JNZERO && !stat.acc_zero);
                            end
                        end
                        ame_pkg::OP_HALT:
                        begin
                            st_reg <= ame_pkg::ST_HALTED;
                            state_reg <= S_DONE;
                        end
                        ame_pkg::OP_OUTPUT:
                        begin
                            print_reg <= 1'b1;
                        end
                        ame_pkg::OP_CHKMEM:
                        begin
                            if (!chk_ok)
                            begin
                                st_reg <= ame_pkg::ST_ERRORED;
                                state_reg <= S_DONE;
                            end
                        end
                        default:
                        begin
                            st_reg <= ame_pkg::ST_ERRORED;
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(W - 1))
                    begin
                        state_reg <= S_ADV;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(W - 1))
                    begin
                        state_reg <= S_DIVD;
                    end
                end
                S_DIVD:
                begin
                    state_reg <= S_ADV;
                end
                S_SHRD:
                begin
                    state_reg <= S_SHWR;
                end
                S_SHWR:
                begin
                    if (op_reg == ame_pkg::OP_INSERT)
                    begin
                        sh_reg <= sh_reg - 1'b1;
                        state_reg <= (sh_reg - 1'b1 == LW'(arg_reg)) ? S_ADV : S_SHRD;
                    end
                    else
                    begin
                        sh_reg <= sh_reg + 1'b1;
                        state_reg <= (sh_reg + 2'd2 == len_reg) ? S_ADV : S_SHRD;
                    end
                end
                S_ADV:
                begin
                    if (op_reg == ame_pkg::OP_INSERT)
                    begin
                        len_reg <= len_reg + 1'b1;
                    end
                    else if (op_reg == ame_pkg::OP_ERASE)
                    begin
                        len_reg <= len_reg - 1'b1;
                    end
                    if (np < 0)
                    begin
                        pc_reg <= '0;
                        if (plen_reg == '0)
                        begin
                            st_reg <= ame_pkg::ST_HALTED;
                        end
                    end
                    else if (np >= $signed({{(SW-PW){1'b0}}, plen_reg}))
                    begin
                        pc_reg <= plen_reg;
                        st_reg <= ame_pkg::ST_HALTED;
                    end
                    else
                    begin
                        pc_reg <= PW'(np);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign arg_q         = arg_reg;
    assign busy          = (state_reg != S_IDLE) || done_reg;
    assign done          = done_reg;
    assign status        = st_reg;
    assign next_pc       = pc_reg;
    assign print_valid   = done_reg && print_reg;
    assign memory_length = len_reg;
endmodule
`default_nettype wire
